### sv/pdte_pkg.sv
// Shared types and constants of the pixel delta terminal encoder.
package pdte_pkg;

    // Stream widths
    localparam int unsigned S_TDATA_W   = 56;
    localparam int unsigned S_TUSER_W   = 4;
    localparam int unsigned M_TDATA_W   = 56;
    localparam int unsigned M_TUSER_W   = 3;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 10;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_MODE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ROW       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_COLUMN    = 3'd4;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_HOME    = 3'd1,
        CMD_MOVE    = 3'd2,
        CMD_BG      = 3'd3,
        CMD_GLYPH   = 3'd4,
        CMD_NEWLINE = 3'd5
    } cmd_t;

    localparam logic [7:0] GLYPH_SPACE = 8'h20;

    // Event bits of one pixel, in emission order
    localparam int unsigned EV_CLEAR     = 0;
    localparam int unsigned EV_HOME      = 1;
    localparam int unsigned EV_ROW_MOVE  = 2;
    localparam int unsigned EV_NEWLINE   = 3;
    localparam int unsigned EV_SKIP_MOVE = 4;
    localparam int unsigned EV_BG        = 5;
    localparam int unsigned EV_GLYPH     = 6;
    localparam int unsigned EV_COUNT     = 7;

    typedef struct packed {
        logic [8:0] col_index;
        logic [7:0] row_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_begin;
        logic       redraw_all;
        logic       no_skip;
        logic       overlay_valid;
        logic [7:0] overlay_char;
    } pixel_t;

    typedef struct packed {
        logic [9:0] color_threshold;
        logic       center_mode;
        logic [8:0] first_row;
        logic [9:0] first_column;
    } cfg_t;

    // Everything the emitter needs to play out one pixel's commands
    typedef struct packed {
        logic [EV_COUNT-1:0] events;
        logic [9:0]          move_row;
        logic [9:0]          move_col;
        logic [9:0]          skip_row;
        logic [9:0]          skip_col;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic                overlay_valid;
        logic [7:0]          overlay_char;
    } run_t;

endpackage

### sv/pdte_fmem.sv
// Frame store memory with registered read and a clearing sweep after reset.
module pdte_fmem #(
    parameter int unsigned Depth = 131072,
    parameter int unsigned AddrW = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [23:0]      rd_data,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [23:0]      wr_data,
    output logic             clearing
);
    logic [23:0]      mem [Depth];
    logic [23:0]      rd_data_reg;
    logic [AddrW-1:0] clr_addr_reg;
    logic             clearing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            if (clr_addr_reg == AddrW'(Depth - 1)) begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

### sv/pdte_decide.sv
// Per-pixel skip and colour decision, frame store update and forwarding.
module pdte_decide #(
    parameter int MaxCols = 512,
    parameter int MaxRows = 256,
    parameter int AddrW   = 17
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pdte_pkg::pixel_t  in_pix,
    input  pdte_pkg::cfg_t    cfg,
    input  logic              clearing,
    output logic              rd_en,
    output logic [AddrW-1:0]  rd_addr,
    input  logic [23:0]       rd_data,
    output logic              wr_en,
    output logic [AddrW-1:0]  wr_addr,
    output logic [23:0]       wr_data,
    input  logic              em_free,
    output logic              run_load,
    output pdte_pkg::run_t    run
);
    import pdte_pkg::*;

    function automatic logic [8:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] d;
        d = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
        return d;
    endfunction

    function automatic logic [9:0] color_dist(input logic [23:0] c, input logic [23:0] p);
        logic [9:0] s;
        s = 10'(absdiff(c[23:16], p[23:16])) + 10'(absdiff(c[15:8], p[15:8]))
            + 10'(absdiff(c[7:0], p[7:0]));
        return s;
    endfunction

    logic             in_inside;
    logic [AddrW-1:0] in_addr;
    logic             accept;
    logic             s1_adv;

    logic             s1_valid_reg;
    pixel_t           s1_pix_reg;
    logic [AddrW-1:0] s1_addr_reg;
    logic             s1_inside_reg;
    logic             fwd_valid_reg;
    logic [AddrW-1:0] fwd_addr_reg;
    logic [23:0]      fwd_data_reg;
    logic             skipping_reg;
    logic [23:0]      last_color_reg;

    logic [23:0]         pix_color;
    logic [23:0]         stored;
    logic [9:0]          dist_stored;
    logic [9:0]          dist_last;
    logic                skip_in;
    logic                skip_px;
    logic                row_start;
    logic [9:0]          pos_row;
    logic [EV_COUNT-1:0] events;

    assign in_inside = (int'(in_pix.col_index) < MaxCols) && (int'(in_pix.row_index) < MaxRows);
    assign in_addr   = AddrW'(in_pix.row_index) * AddrW'(MaxCols) + AddrW'(in_pix.col_index);

    assign s1_adv   = s1_valid_reg && em_free;
    assign in_ready = !clearing && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;
    assign rd_en    = accept;
    assign rd_addr  = in_inside ? in_addr : '0;

    // Read that met a write to the same entry at the same edge sees the old word
    assign pix_color = {s1_pix_reg.red, s1_pix_reg.green, s1_pix_reg.blue};
    always_comb begin
        if (!s1_inside_reg) begin
            stored = '0;
        end else if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) begin
            stored = fwd_data_reg;
        end else begin
            stored = rd_data;
        end
    end

    assign dist_stored = color_dist(stored, pix_color);
    assign dist_last   = color_dist(last_color_reg, pix_color);
    assign skip_in     = s1_pix_reg.frame_begin ? 1'b0 : skipping_reg;
    assign skip_px     = !s1_pix_reg.no_skip && !s1_pix_reg.redraw_all
                         && (dist_stored < cfg.color_threshold);
    assign row_start   = (s1_pix_reg.col_index == '0);
    assign pos_row     = 10'(cfg.first_row) + 10'(s1_pix_reg.row_index);

    always_comb begin
        events               = '0;
        events[EV_CLEAR]     = s1_pix_reg.frame_begin && s1_pix_reg.redraw_all;
        events[EV_HOME]      = s1_pix_reg.frame_begin;
        events[EV_ROW_MOVE]  = row_start && cfg.center_mode;
        events[EV_NEWLINE]   = row_start && !cfg.center_mode && (s1_pix_reg.row_index != '0);
        events[EV_SKIP_MOVE] = !skip_px && skip_in;
        events[EV_BG]        = !skip_px
                               && (s1_pix_reg.redraw_all || (dist_last > cfg.color_threshold));
        events[EV_GLYPH]     = !skip_px;
    end

    always_comb begin
        run.events        = events;
        run.move_row      = pos_row;
        run.move_col      = cfg.first_column;
        run.skip_row      = cfg.center_mode ? pos_row : 10'(s1_pix_reg.row_index) + 10'd1;
        run.skip_col      = cfg.center_mode ? cfg.first_column + 10'(s1_pix_reg.col_index)
                                            : 10'(s1_pix_reg.col_index) + 10'd1;
        run.red           = s1_pix_reg.red;
        run.green         = s1_pix_reg.green;
        run.blue          = s1_pix_reg.blue;
        run.overlay_valid = s1_pix_reg.overlay_valid;
        run.overlay_char  = s1_pix_reg.overlay_char;
    end

    assign run_load = s1_adv;
    assign wr_en    = s1_adv && !skip_px && s1_inside_reg;
    assign wr_addr  = s1_addr_reg;
    assign wr_data  = pix_color;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            skipping_reg   <= 1'b0;
            last_color_reg <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg  <= 1'b1;
                fwd_valid_reg <= wr_en;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                skipping_reg <= skip_px;
                if (events[EV_BG]) begin
                    last_color_reg <= pix_color;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg    <= in_pix;
            s1_addr_reg   <= in_addr;
            s1_inside_reg <= in_inside;
            fwd_addr_reg  <= wr_addr;
            fwd_data_reg  <= wr_data;
        end
    end

endmodule

### sv/pdte_emit.sv
// Command emitter: plays out one pixel's pending events, one item per cycle while the output is not stalled.
module pdte_emit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              run_load,
    input  pdte_pkg::run_t                    run,
    output logic                              em_free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pdte_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [pdte_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tlast
);
    import pdte_pkg::*;

    logic [EV_COUNT-1:0] pend_reg;
    run_t                run_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    cmd_t                m_tuser_reg;
    logic                m_tlast_reg;

    logic [EV_COUNT-1:0] sel;
    logic [EV_COUNT-1:0] rest;
    logic                out_free;
    logic                pop;
    cmd_t                cmd;
    logic [9:0]          row;
    logic [9:0]          col;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [7:0]          code;
    logic                colored;

    assign sel      = pend_reg & (~pend_reg + 1'b1);
    assign rest     = pend_reg & ~sel;
    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = out_free && (pend_reg != '0);
    assign em_free  = (pend_reg == '0) || (pop && (rest == '0));

    always_comb begin
        cmd     = CMD_GLYPH;
        row     = '0;
        col     = '0;
        red     = '0;
        green   = '0;
        blue    = '0;
        code    = '0;
        colored = 1'b0;
        if (sel[EV_CLEAR]) begin
            cmd = CMD_CLEAR;
        end else if (sel[EV_HOME]) begin
            cmd = CMD_HOME;
        end else if (sel[EV_ROW_MOVE]) begin
            cmd = CMD_MOVE;
            row = run_reg.move_row;
            col = run_reg.move_col;
        end else if (sel[EV_NEWLINE]) begin
            cmd = CMD_NEWLINE;
        end else if (sel[EV_SKIP_MOVE]) begin
            cmd = CMD_MOVE;
            row = run_reg.skip_row;
            col = run_reg.skip_col;
        end else if (sel[EV_BG]) begin
            cmd   = CMD_BG;
            red   = run_reg.red;
            green = run_reg.green;
            blue  = run_reg.blue;
        end else if (run_reg.overlay_valid) begin
            // overlay glyph in inverted colour
            red     = 8'hFF - run_reg.red;
            green   = 8'hFF - run_reg.green;
            blue    = 8'hFF - run_reg.blue;
            code    = run_reg.overlay_char;
            colored = 1'b1;
        end else begin
            code = GLYPH_SPACE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (run_load) begin
                pend_reg <= run.events;
            end else if (pop) begin
                pend_reg <= rest;
            end
            if (pop) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (run_load) begin
            run_reg <= run;
        end
        if (pop) begin
            m_tdata_reg <= {3'b000, colored, code, blue, green, red, col, row};
            m_tuser_reg <= cmd;
            m_tlast_reg <= (rest == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### sv/pixel_delta_terminal_encoder_unit.sv
// Top level of the pixel delta terminal encoder.
//
// Takes scaled RGB pixels in raster order and emits terminal commands (clear, home,
// cursor move, background colour, glyph, newline), one command per output item, with
// m_tlast on the last command of each pixel. The previous frame lives in a
// MAX_COLS x MAX_ROWS frame store memory; a pixel reads it when accepted, the decision
// stage compares and, unless the pixel is skipped, writes it back, and a write that
// meets a read of the same entry is forwarded. A pixel occupies the single output
// channel for the commands it produces (zero to five), sent one per cycle while m_tready
// is high; pixels that produce nothing go at one per cycle while the emitter is idle.
// The first command of a pixel passes from the decision register through the emitter's
// pending events to the output register before it is offered on m_tvalid. After reset the
// store is swept to zero, one entry per cycle, over all MAX_COLS * MAX_ROWS entries
// (131072 with the defaults) before the first pixel is taken; configuration writes are
// taken throughout. The frame_rows register is accepted but has no effect on the output.
module pixel_delta_terminal_encoder_unit #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // col_index, row_index, red, green, blue, overlay_char from bit 0, zero padded
    input  logic [pdte_pkg::S_TDATA_W-1:0]      s_tdata,
    // frame_begin, redraw_all, no_skip, overlay_valid from bit 0
    input  logic [pdte_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // term_row, term_col, out_red, out_green, out_blue, glyph_code, glyph_colored
    // from bit 0, zero padded
    output logic [pdte_pkg::M_TDATA_W-1:0]      m_tdata,
    // command
    output logic [pdte_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pdte_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pdte_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pdte_pkg::*;

    localparam int Depth = MAX_COLS * MAX_ROWS;
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

    cfg_t             cfg_reg;
    pixel_t           in_pix;
    run_t             run;
    logic             run_load;
    logic             em_free;
    logic             clearing;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic [23:0]      rd_data;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [23:0]      wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.color_threshold <= '0;
            cfg_reg.center_mode     <= 1'b1;
            cfg_reg.first_row       <= 9'd1;
            cfg_reg.first_column    <= 10'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COLOR_THRESHOLD: cfg_reg.color_threshold <= cfg_data;
                REG_CENTER_MODE:     cfg_reg.center_mode     <= cfg_data[0];
                REG_FIRST_ROW:       cfg_reg.first_row       <= cfg_data[8:0];
                REG_FIRST_COLUMN:    cfg_reg.first_column    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_pix.col_index     = s_tdata[8:0];
        in_pix.row_index     = s_tdata[16:9];
        in_pix.red           = s_tdata[24:17];
        in_pix.green         = s_tdata[32:25];
        in_pix.blue          = s_tdata[40:33];
        in_pix.overlay_char  = s_tdata[48:41];
        in_pix.frame_begin   = s_tuser[0];
        in_pix.redraw_all    = s_tuser[1];
        in_pix.no_skip       = s_tuser[2];
        in_pix.overlay_valid = s_tuser[3];
    end

    pdte_fmem #(
        .Depth (Depth),
        .AddrW (AddrW)
    ) u_fmem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    pdte_decide #(
        .MaxCols (MAX_COLS),
        .MaxRows (MAX_ROWS),
        .AddrW   (AddrW)
    ) u_decide (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_pix   (in_pix),
        .cfg      (cfg_reg),
        .clearing (clearing),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .em_free  (em_free),
        .run_load (run_load),
        .run      (run)
    );

    pdte_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .run_load (run_load),
        .run      (run),
        .em_free  (em_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sv/pdte_checker.sv
// Port-level checks on the encoder's command stream, bound to the top level.
module pdte_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pdte_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [pdte_pkg::M_TUSER_W-1:0]    m_tuser,
    input logic                              m_tlast
);
    import pdte_pkg::*;

    // Hold a stalled item
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output item changed");

    // Only cursor moves carry coordinates
    a_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != CMD_MOVE) |-> (m_tdata[19:0] == '0))
        else $error("coordinates on a non-move command");

    // A glyph always closes its pixel; a clear never does
    a_glyph_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CMD_GLYPH) |-> m_tlast)
        else $error("glyph not last of its pixel");

    a_clear_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CMD_CLEAR) |-> !m_tlast)
        else $error("clear without a following home");

    // Plain glyph is an uncoloured space
    a_plain_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CMD_GLYPH) && !m_tdata[52]
        |-> (m_tdata[51:44] == GLYPH_SPACE) && (m_tdata[43:20] == '0))
        else $error("plain glyph is not a space");

endmodule

bind pixel_delta_terminal_encoder_unit pdte_checker u_pdte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/tb.sv
// Testbench of the pixel delta terminal encoder: random pixel frames against a command predictor.
module tb;
    import pdte_pkg::*;

    localparam int unsigned QUIET_LIMIT = 400000; // store sweep after reset plus margin
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct packed {
        cmd_t       command;
        logic [9:0] term_row;
        logic [9:0] term_col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] glyph_code;
        logic       glyph_colored;
        logic       last;
    } term_cmd_t;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic [S_TDATA_W-1:0]     s_tdata = '0;
    logic [S_TUSER_W-1:0]     s_tuser = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic [M_TUSER_W-1:0]     m_tuser;
    logic                     m_tlast;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    pixel_delta_terminal_encoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: previous frame, last background sent, skip flag, registers
    bit   [23:0] prev_frame [0:(1<<17)-1];
    logic [23:0] last_bg = '0;
    logic        in_skip = 1'b0;
    logic [9:0]  thr_reg = 10'd0;
    logic        centered = 1'b1;
    logic [8:0]  origin_row = 9'd1;
    logic [9:0]  origin_col = 10'd1;

    term_cmd_t   pending_cmds [$];
    logic [S_TUSER_W+S_TDATA_W-1:0] pix_q [$];
    int unsigned pix_total = 0;
    int unsigned pix_accepted = 0;
    int unsigned cfg_done = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned tx_idle_pct = 36;
    int unsigned rx_idle_pct = 46;
    int unsigned hold_at = 32'hFFFF_FFFF;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    logic        s_acc = 1'b0;
    bit   [23:0] scene [0:3][0:5];

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned chan_gap(logic [7:0] a, logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int unsigned color_gap(logic [23:0] c, logic [23:0] rgb);
        return chan_gap(c[23:16], rgb[23:16]) + chan_gap(c[15:8], rgb[15:8])
             + chan_gap(c[7:0], rgb[7:0]);
    endfunction

    function automatic void emit_cmd(cmd_t c, logic [9:0] row, logic [9:0] col,
                                     logic [23:0] rgb, logic [7:0] code, logic colored);
        term_cmd_t t;
        t.command       = c;
        t.term_row      = row;
        t.term_col      = col;
        t.red           = rgb[23:16];
        t.green         = rgb[15:8];
        t.blue          = rgb[7:0];
        t.glyph_code    = code;
        t.glyph_colored = colored;
        t.last          = 1'b0;
        pending_cmds.insert(pending_cmds.size(), t);
    endfunction

    // Work out the commands one pixel causes and queue them in order
    function automatic void encode_pixel(pixel_t p);
        logic [16:0] addr;
        logic [23:0] rgb;
        logic [23:0] stored;
        int unsigned base;
        term_cmd_t   tail;
        addr   = {p.row_index, p.col_index};
        rgb    = {p.red, p.green, p.blue};
        stored = prev_frame[addr];
        base   = pending_cmds.size();
        if (p.frame_begin) begin
            in_skip = 1'b0;
            if (p.redraw_all)
                emit_cmd(CMD_CLEAR, 10'd0, 10'd0, 24'd0, 8'd0, 1'b0);
            emit_cmd(CMD_HOME, 10'd0, 10'd0, 24'd0, 8'd0, 1'b0);
        end
        // Row start commands go out even if the pixel is then skipped
        if (p.col_index == 9'd0) begin
            if (centered)
                emit_cmd(CMD_MOVE, {1'b0, origin_row} + {2'b0, p.row_index}, origin_col,
                         24'd0, 8'd0, 1'b0);
            else if (p.row_index != 8'd0)
                emit_cmd(CMD_NEWLINE, 10'd0, 10'd0, 24'd0, 8'd0, 1'b0);
        end
        if (!p.no_skip && !p.redraw_all && color_gap(stored, rgb) < thr_reg) begin
            in_skip = 1'b1;
        end else begin
            if (in_skip) begin
                in_skip = 1'b0;
                if (centered)
                    emit_cmd(CMD_MOVE, {1'b0, origin_row} + {2'b0, p.row_index},
                             origin_col + {1'b0, p.col_index}, 24'd0, 8'd0, 1'b0);
                else
                    emit_cmd(CMD_MOVE, {2'b0, p.row_index} + 10'd1,
                             {1'b0, p.col_index} + 10'd1, 24'd0, 8'd0, 1'b0);
            end
            prev_frame[addr] = rgb;
            if (p.redraw_all || color_gap(last_bg, rgb) > thr_reg) begin
                last_bg = rgb;
                emit_cmd(CMD_BG, 10'd0, 10'd0, rgb, 8'd0, 1'b0);
            end
            if (p.overlay_valid)
                emit_cmd(CMD_GLYPH, 10'd0, 10'd0, ~rgb, p.overlay_char, 1'b1);
            else
                emit_cmd(CMD_GLYPH, 10'd0, 10'd0, 24'd0, GLYPH_SPACE, 1'b0);
        end
        if (pending_cmds.size() > base) begin
            tail = pending_cmds.pop_back();
            tail.last = 1'b1;
            pending_cmds.insert(pending_cmds.size(), tail);
        end
    endfunction

    function automatic string fmt_cmd(term_cmd_t c);
        return $sformatf("cmd=%0d row=%0d col=%0d rgb=%02h%02h%02h code=%02h colored=%0b last=%0b",
                         c.command, c.term_row, c.term_col, c.red, c.green, c.blue,
                         c.glyph_code, c.glyph_colored, c.last);
    endfunction

    // Monitor: register writes, accepted pixels, and checking of result items
    always @(posedge aclk) begin : monitor
        pixel_t    pix;
        term_cmd_t got;
        term_cmd_t want;
        s_acc <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_COLOR_THRESHOLD: thr_reg    = cfg_data;
                    REG_CENTER_MODE:     centered   = cfg_data[0];
                    // frame_rows has no effect on the commands
                    REG_FRAME_ROWS:      ;
                    REG_FIRST_ROW:       origin_row = cfg_data[8:0];
                    REG_FIRST_COLUMN:    origin_col = cfg_data;
                    default: ;
                endcase
                cfg_done++;
            end
            if (s_tvalid && s_tready) begin
                pix.col_index     = s_tdata[8:0];
                pix.row_index     = s_tdata[16:9];
                pix.red           = s_tdata[24:17];
                pix.green         = s_tdata[32:25];
                pix.blue          = s_tdata[40:33];
                pix.overlay_char  = s_tdata[48:41];
                pix.frame_begin   = s_tuser[0];
                pix.redraw_all    = s_tuser[1];
                pix.no_skip       = s_tuser[2];
                pix.overlay_valid = s_tuser[3];
                encode_pixel(pix);
                pix_accepted++;
            end
            if (m_tvalid && m_tready) begin
                got.command       = cmd_t'(m_tuser);
                got.term_row      = m_tdata[9:0];
                got.term_col      = m_tdata[19:10];
                got.red           = m_tdata[27:20];
                got.green         = m_tdata[35:28];
                got.blue          = m_tdata[43:36];
                got.glyph_code    = m_tdata[51:44];
                got.glyph_colored = m_tdata[52];
                got.last          = m_tlast;
                if (pending_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: %s", fmt_cmd(got));
                end else begin
                    want = pending_cmds.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %s / actual %s",
                                     fmt_cmd(want), fmt_cmd(got));
                    end
                end
            end
        end
    end

    // Driver: hold the offered item until taken, then maybe idle
    always @(negedge aclk) begin
        if (!(s_tvalid && !s_acc)) begin
            if (pix_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_tvalid <= 1'b1;
                {s_tuser, s_tdata} <= pix_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back up the input
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && pix_accepted >= hold_at) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        int unsigned target;
        target = cfg_done + 1;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (cfg_done != target);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_cfg(input logic [9:0] thr, input logic ctr, input logic [9:0] rows,
                           input logic [9:0] frow, input logic [9:0] fcol);
        write_reg(REG_COLOR_THRESHOLD, thr);
        write_reg(REG_CENTER_MODE, {9'd0, ctr});
        write_reg(REG_FRAME_ROWS, rows);
        write_reg(REG_FIRST_ROW, frow);
        write_reg(REG_FIRST_COLUMN, fcol);
    endtask

    task automatic add_pixel(input logic [8:0] x, input logic [7:0] y, input logic [23:0] rgb,
                             input bit fb, input bit frc, input bit ns, input bit ov,
                             input logic [7:0] ch);
        pix_q.insert(pix_q.size(),
                     {ov, ns, frc, fb, 7'd0, ch, rgb[7:0], rgb[15:8], rgb[23:16], y, x});
        pix_total++;
    endtask

    // Wait until every pixel is taken and every command seen, then let stragglers drain
    task automatic settle();
        while (!(pix_accepted == pix_total && pending_cmds.size() == 0))
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [7:0] nudge(logic [7:0] c);
        int v;
        v = c;
        v = v + int'($urandom_range(12)) - 6;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // One raster frame; most pixels stay near the previous frame so skipping kicks in
    task automatic gen_frame(input int w, input int h, input bit frc);
        logic [23:0] rgb;
        int unsigned sel;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                sel = $urandom_range(99);
                if (sel < 60)
                    rgb = {nudge(scene[y][x][23:16]), nudge(scene[y][x][15:8]),
                           nudge(scene[y][x][7:0])};
                else if (sel < 85)
                    rgb = 24'($urandom);
                else
                    rgb = {{8{sel[0]}}, {8{sel[1]}}, {8{sel[2]}}};
                scene[y][x] = rgb;
                add_pixel(9'(x), 8'(y), rgb, (x == 0 && y == 0), frc,
                          ($urandom_range(99) < 15), ($urandom_range(99) < 25),
                          8'($urandom_range(255)));
            end
        end
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned start;
        start = pix_total;
        while (pix_total - start < n_items) begin
            if ($urandom_range(9) == 0)
                add_pixel(9'($urandom_range(511)), 8'($urandom_range(255)), 24'($urandom),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
            else
                gen_frame(int'($urandom_range(1, 6)), int'($urandom_range(1, 4)),
                          ($urandom_range(99) < 15));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Zero threshold, centered at the top left corner: nothing is skipped
        set_cfg(10'd0, 1'b1, 10'd1, 10'd1, 10'd1);
        add_pixel(9'd0, 8'd0, 24'h000000, 1'b1, 1'b1, 1'b0, 1'b1, 8'hFF);
        add_pixel(9'd1, 8'd0, 24'hFFFFFF, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
        add_pixel(9'd511, 8'd255, 24'hFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd0, 8'd255, 24'h123456, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd0, 8'd0, 24'h000000, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
        settle();

        // Largest threshold and origin: skip everything unprotected, moves at the far corner
        set_cfg(10'd1023, 1'b1, 10'd256, 10'd256, 10'd512);
        add_pixel(9'd0, 8'd0, 24'h000000, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd1, 8'd0, 24'h000000, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd511, 8'd255, 24'hFFFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
        add_pixel(9'd0, 8'd1, 24'hA5A5A5, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd5, 8'd3, 24'h00FF00, 1'b0, 1'b0, 1'b0, 1'b1, 8'h41);
        add_pixel(9'd6, 8'd3, 24'h0000FF, 1'b0, 1'b0, 1'b1, 1'b1, 8'h41);
        settle();

        // Newline mode: row zero has no newline, moves after skips are one based
        set_cfg(10'd20, 1'b0, 10'd1, 10'd1, 10'd1);
        add_pixel(9'd0, 8'd0, 24'h808080, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd1, 8'd0, 24'h808082, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd0, 8'd1, 24'h000000, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd1, 8'd1, 24'h000000, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd2, 8'd1, 24'hFF0000, 1'b0, 1'b0, 1'b0, 1'b1, 8'h7E);
        add_pixel(9'd0, 8'd2, 24'h000000, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd1, 8'd2, 24'h0A0A0A, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd3, 8'd3, 24'h000001, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_pixel(9'd0, 8'd0, 24'h808080, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
        settle();

        set_cfg(10'($urandom_range(1, 60)), 1'b0, 10'($urandom_range(1, 256)),
                10'($urandom_range(1, 256)), 10'($urandom_range(1, 512)));
        random_phase(50);
        settle();

        tx_idle_pct = 46;
        rx_idle_pct = 36;
        set_cfg(10'($urandom_range(0, 100)), 1'b1, 10'($urandom_range(1, 256)),
                10'($urandom_range(1, 256)), 10'($urandom_range(1, 512)));
        random_phase(50);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_cfg(10'($urandom_range(1, 40)), 1'($urandom_range(1)),
                10'($urandom_range(1, 256)), 10'($urandom_range(1, 256)),
                10'($urandom_range(1, 512)));
        hold_at = pix_accepted + 20;
        random_phase(50);
        settle();

        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
